// ===== sv/wtsp_pkg.sv =====
// Shared types and constants for the world-to-screen projection pipeline.
// No dependencies.
package wtsp_pkg;

	localparam int ACC_W   = 64;           // clip accumulator width
	localparam int SIZE_W  = 13;           // screen size width
	localparam int PIX_W   = 16;           // pixel coordinate width
	localparam int QUO_W   = 16;           // quotient bits below saturation
	localparam int MPROD_W = ACC_W + SIZE_W;
	localparam int DIV_LAT = QUO_W + 3;    // register stages in a divider lane

	typedef enum logic [2:0] {
		REG_ROW_X    = 3'd0,
		REG_ROW_Y    = 3'd1,
		REG_ROW_W    = 3'd2,
		REG_OFFSET_X = 3'd3,
		REG_OFFSET_Y = 3'd4,
		REG_OFFSET_W = 3'd5,
		REG_WIDTH    = 3'd6,
		REG_HEIGHT   = 3'd7
	} wtsp_reg_t;

	// quotient leaving a divider lane
	typedef struct packed {
		logic             neg;   // numerator was negative
		logic             sat;   // quotient reached 2^16 or more
		logic [QUO_W-1:0] quo;   // magnitude when not saturated
	} wtsp_quo_t;

endpackage

// ===== sv/wtsp_affine_row.sv =====
// One affine row: three coefficient products, then the sum with the offset.
// Depends on wtsp_pkg. Both the products and the sum are registered.
module wtsp_affine_row import wtsp_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int COEFF_WIDTH = 16
) (
	input  logic                     clk,
	input  logic [3*COEFF_WIDTH-1:0] coeffs,
	input  logic [COORD_WIDTH-1:0]   offset,
	input  logic [COORD_WIDTH-1:0]   pos_x,
	input  logic [COORD_WIDTH-1:0]   pos_y,
	input  logic [COORD_WIDTH-1:0]   pos_z,
	output logic [ACC_W-1:0]         acc
);

	localparam int PROD_W     = COORD_WIDTH + COEFF_WIDTH;
	localparam int COEFF_FRAC = COEFF_WIDTH - 4;

	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [ACC_W-1:0]  off_term;

	always_ff @(posedge clk) begin
		prod_x_s1 <= $signed(coeffs[COEFF_WIDTH-1:0]) * $signed(pos_x);
		prod_y_s1 <= $signed(coeffs[2*COEFF_WIDTH-1:COEFF_WIDTH]) * $signed(pos_y);
		prod_z_s1 <= $signed(coeffs[3*COEFF_WIDTH-1:2*COEFF_WIDTH]) * $signed(pos_z);
	end

	assign off_term = ACC_W'($signed(offset)) <<< COEFF_FRAC;

	// sum wraps modulo 2^64
	always_ff @(posedge clk) begin
		acc <= ACC_W'(off_term + ACC_W'(prod_x_s1) + ACC_W'(prod_y_s1) + ACC_W'(prod_z_s1));
	end

endmodule

// ===== sv/wtsp_div_lane.sv =====
// Divider lane: trunc(size * |num| / den), one quotient bit per stage.
// Depends on wtsp_pkg. One beat per cycle.
module wtsp_div_lane import wtsp_pkg::*; (
	input  logic              clk,
	input  logic [ACC_W-1:0]  num,
	input  logic [ACC_W-1:0]  den,
	input  logic [SIZE_W-1:0] size,
	output wtsp_quo_t         res
);

	logic               neg_s1;
	logic [ACC_W-1:0]   mag_s1, den_s1;
	logic               neg_s2;
	logic [MPROD_W-1:0] prod_s2;
	logic [ACC_W-1:0]   den_s2;

	logic [ACC_W-1:0] rem_s [QUO_W+1];
	logic [QUO_W-1:0] lo_s  [QUO_W+1];
	logic [QUO_W-1:0] q_s   [QUO_W+1];
	logic [ACC_W-1:0] dd_s  [QUO_W+1];
	logic             neg_s [QUO_W+1];
	logic             sat_s [QUO_W+1];

	always_ff @(posedge clk) begin
		neg_s1 <= num[ACC_W-1];
		mag_s1 <= num[ACC_W-1] ? ACC_W'(-num) : num;
		den_s1 <= den;
	end

	always_ff @(posedge clk) begin
		neg_s2  <= neg_s1;
		prod_s2 <= MPROD_W'(mag_s1) * MPROD_W'(size);
		den_s2  <= den_s1;
	end

	// saturation check, then remainder seeded with the high product bits
	always_ff @(posedge clk) begin
		sat_s[0] <= {{(ACC_W+QUO_W-MPROD_W){1'b0}}, prod_s2} >= {den_s2, {QUO_W{1'b0}}};
		rem_s[0] <= ACC_W'(prod_s2[MPROD_W-1:QUO_W]);
		lo_s[0]  <= prod_s2[QUO_W-1:0];
		q_s[0]   <= '0;
		dd_s[0]  <= den_s2;
		neg_s[0] <= neg_s2;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [ACC_W:0] sh;
		logic           ge;
		assign sh = {rem_s[k], lo_s[k][QUO_W-1]};
		assign ge = sh >= {1'b0, dd_s[k]};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? ACC_W'(sh - {1'b0, dd_s[k]}) : sh[ACC_W-1:0];
			q_s[k+1]   <= {q_s[k][QUO_W-2:0], ge};
			lo_s[k+1]  <= {lo_s[k][QUO_W-2:0], 1'b0};
			dd_s[k+1]  <= dd_s[k];
			neg_s[k+1] <= neg_s[k];
			sat_s[k+1] <= sat_s[k];
		end
	end

	assign res = '{neg: neg_s[QUO_W], sat: sat_s[QUO_W], quo: q_s[QUO_W]};

endmodule

// ===== sv/world_to_screen_projection_unit.sv =====
// Top level of the world-to-screen projection pipeline.
// Depends on wtsp_pkg, wtsp_affine_row and wtsp_div_lane.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  command  | start, busy (always low)   | pos_x, pos_y, pos_z
//  result   | result_valid (one cycle)   | visible, screen_x, screen_y
//  config   | cfg_we                     | cfg_index, cfg_data
//
// One beat enters per cycle; results leave in the order of their starts.
// The divider lanes take one quotient bit per stage, 16 stages, and the pipeline has
// two stages for the affine rows, one for numerators and depth test,
// three for magnitude, scale multiply and saturation check, and the output.
// arst_n clears the valid pipe and loads register reset values.
// The receiver cannot stall, so busy never rises and nothing is held.
module world_to_screen_projection_unit import wtsp_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int COEFF_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_WIDTH-1:0] pos_x,
	input  logic [COORD_WIDTH-1:0] pos_y,
	input  logic [COORD_WIDTH-1:0] pos_z,
	output logic                   result_valid,
	output logic                   visible,
	output logic [PIX_W-1:0]       screen_x,
	output logic [PIX_W-1:0]       screen_y,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [((3*COEFF_WIDTH > COORD_WIDTH) ? 3*COEFF_WIDTH : COORD_WIDTH)-1:0] cfg_data
);

	localparam int ROW_W     = 3 * COEFF_WIDTH;
	localparam int CLIP_FRAC = COEFF_WIDTH - 4 + 16;
	// depth below 0.1 exactly when w <= floor((2^CLIP_FRAC - 1) / 10)
	localparam logic [ACC_W-1:0] NEAR_LIMIT = ACC_W'(((64'd1 << CLIP_FRAC) - 64'd1) / 64'd10);
	localparam logic [COORD_WIDTH-1:0] OFFSET_W_RST = COORD_WIDTH'(65536);

	// configuration registers
	logic [ROW_W-1:0]       row_x_q, row_y_q, row_w_q;
	logic [COORD_WIDTH-1:0] off_x_q, off_y_q, off_w_q;
	logic [SIZE_W-1:0]      width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= '0;
			row_y_q  <= '0;
			row_w_q  <= '0;
			off_x_q  <= '0;
			off_y_q  <= '0;
			off_w_q  <= OFFSET_W_RST;
			width_q  <= SIZE_W'(1920);
			height_q <= SIZE_W'(1080);
		end else if (cfg_we) begin
			unique case (wtsp_reg_t'(cfg_index))
				REG_ROW_X:    row_x_q  <= cfg_data[ROW_W-1:0];
				REG_ROW_Y:    row_y_q  <= cfg_data[ROW_W-1:0];
				REG_ROW_W:    row_w_q  <= cfg_data[ROW_W-1:0];
				REG_OFFSET_X: off_x_q  <= cfg_data[COORD_WIDTH-1:0];
				REG_OFFSET_Y: off_y_q  <= cfg_data[COORD_WIDTH-1:0];
				REG_OFFSET_W: off_w_q  <= cfg_data[COORD_WIDTH-1:0];
				REG_WIDTH:    width_q  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:   height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// s1..s2: affine rows
	logic [ACC_W-1:0] cx_s2, cy_s2, cw_s2;

	wtsp_affine_row #(.COORD_WIDTH(COORD_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_row_x (
		.clk(clk), .coeffs(row_x_q), .offset(off_x_q),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .acc(cx_s2)
	);
	wtsp_affine_row #(.COORD_WIDTH(COORD_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_row_y (
		.clk(clk), .coeffs(row_y_q), .offset(off_y_q),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .acc(cy_s2)
	);
	wtsp_affine_row #(.COORD_WIDTH(COORD_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_row_w (
		.clk(clk), .coeffs(row_w_q), .offset(off_w_q),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .acc(cw_s2)
	);

	// s3: numerators w+x and w-y over 2w, depth test
	logic [ACC_W-1:0] num_x_s3, num_y_s3, den_s3;
	logic             front_s3;

	always_ff @(posedge clk) begin
		num_x_s3 <= cw_s2 + cx_s2;
		num_y_s3 <= cw_s2 - cy_s2;
		den_s3   <= {cw_s2[ACC_W-2:0], 1'b0};
		front_s3 <= $signed(cw_s2) > $signed(NEAR_LIMIT);
	end

	wtsp_quo_t qx, qy;

	wtsp_div_lane u_div_x (
		.clk(clk), .num(num_x_s3), .den(den_s3), .size(width_q), .res(qx)
	);
	wtsp_div_lane u_div_y (
		.clk(clk), .num(num_y_s3), .den(den_s3), .size(height_q), .res(qy)
	);

	// depth flag rides alongside the lanes
	logic front_s [DIV_LAT];

	always_ff @(posedge clk) begin
		front_s[0] <= front_s3;
		for (int i = 1; i < DIV_LAT; i++) begin
			front_s[i] <= front_s[i-1];
		end
	end

	// valid bits: three front stages, then the lanes
	logic vld_s1, vld_s2, vld_s3;
	logic vld_s [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
			result_valid <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s[0] <= vld_s3;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			result_valid <= vld_s[DIV_LAT-1];
		end
	end

	// signed saturation of a lane quotient to 16 bits
	function automatic logic [PIX_W-1:0] to_pixel(input wtsp_quo_t q);
		logic [PIX_W-1:0] r;
		if (q.neg) begin
			r = (q.sat || q.quo > PIX_W'(32768)) ? PIX_W'(16'h8000) : PIX_W'(-q.quo);
		end else begin
			r = (q.sat || q.quo > PIX_W'(32767)) ? PIX_W'(16'h7FFF) : q.quo;
		end
		return r;
	endfunction

	logic [PIX_W-1:0] px, py;
	logic             vis;

	assign px  = to_pixel(qx);
	assign py  = to_pixel(qy);
	assign vis = front_s[DIV_LAT-1] && (px != '0) && (py != '0);

	// output beat
	always_ff @(posedge clk) begin
		visible  <= vis;
		screen_x <= vis ? px : '0;
		screen_y <= vis ? py : '0;
	end

endmodule
